/* src/otq_pkg.sv */
package otq_pkg;

  // Timer ids are four bits wide, so no more than this many timers can exist.
  localparam int unsigned MAX_IDS = 16;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_MODIFY  = 2'd2,
    CMD_ADVANCE = 2'd3
  } otq_cmd_t;

  typedef enum logic [1:0] {
    KIND_DONE  = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_ERROR = 2'd2
  } otq_kind_t;

  typedef enum logic [1:0] {
    ST_NOP    = 2'd0,
    ST_REMOVE = 2'd1,
    ST_INSERT = 2'd2
  } otq_store_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEL_SCAN,
    S_ADD_CHK,
    S_ADD_SCAN,
    S_ADV_CHK,
    S_ADV_FIRE,
    S_RESULT
  } otq_state_t;

  // One queued timer.
  typedef struct packed {
    logic [3:0]  id;
    logic [31:0] coarse;
    logic [19:0] fine;
  } otq_entry_t;

  // Request from the sequencer to the timer store.
  typedef struct packed {
    otq_store_op_t op;
    otq_entry_t    entry;
  } otq_store_req_t;

  // One result transaction.
  typedef struct packed {
    otq_kind_t   kind;
    logic [3:0]  fired_id;
    logic [31:0] time_coarse;
    logic [19:0] time_fine;
    logic        was_present;
    logic        last;
  } otq_result_t;

endpackage

/* src/otq_in_if.sv */
interface otq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [3:0]  timer_id;
  logic [31:0] deadline_coarse;
  logic [19:0] deadline_fine;

  modport source (
    output valid, cmd, timer_id, deadline_coarse, deadline_fine,
    input  ready
  );
  modport sink (
    input  valid, cmd, timer_id, deadline_coarse, deadline_fine,
    output ready
  );
endinterface

/* src/otq_out_if.sv */
interface otq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  fired_id;
  logic [31:0] time_coarse;
  logic [19:0] time_fine;
  logic        was_present;
  logic        last;

  modport source (
    output valid, kind, fired_id, time_coarse, time_fine, was_present, last,
    input  ready
  );
  modport sink (
    input  valid, kind, fired_id, time_coarse, time_fine, was_present, last,
    output ready
  );
endinterface

/* src/otq_cmp.sv */
// Shared compare unit: two-part deadline less-than and id match.
module otq_cmp (
  input  logic [3:0]  a_id,
  input  logic [31:0] a_coarse,
  input  logic [19:0] a_fine,
  input  logic [3:0]  b_id,
  input  logic [31:0] b_coarse,
  input  logic [19:0] b_fine,
  output logic        a_lt_b,
  output logic        id_eq
);

  // Coarse tick decides first, the fine sub-tick breaks a tie.
  assign a_lt_b = (a_coarse < b_coarse) ||
                  ((a_coarse == b_coarse) && (a_fine < b_fine));
  assign id_eq  = (a_id == b_id);

endmodule

/* src/otq_store.sv */
// Sorted timer store. Each entry moves only to or from its direct
// neighbor, so a removal or an insertion shifts the entries from pos onward together.
module otq_store #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                    clk,
  input  otq_pkg::otq_store_req_t req,
  input  logic [$clog2(DEPTH)-1:0] pos,
  input  logic [$clog2(DEPTH)-1:0] rd_idx,
  output otq_pkg::otq_entry_t     rd_entry
);

  localparam int unsigned IW = $clog2(DEPTH);

  otq_pkg::otq_entry_t slot_r [DEPTH];

  // Single read port at the scan position.
  assign rd_entry = slot_r[rd_idx];

  for (genvar j = 0; j < DEPTH; j++) begin : g_ent
    otq_pkg::otq_entry_t from_prev;
    otq_pkg::otq_entry_t from_next;

    if (j == 0) begin : g_first
      assign from_prev = req.entry;
    end else begin : g_prev
      assign from_prev = slot_r[j-1];
    end

    if (j == DEPTH - 1) begin : g_lastent
      assign from_next = slot_r[j];
    end else begin : g_next
      assign from_next = slot_r[j+1];
    end

    // Removal closes the gap at pos; insertion opens one there.
    always_ff @(posedge clk) begin
      unique case (req.op)
        otq_pkg::ST_REMOVE: begin
          if (IW'(j) >= pos) begin
            slot_r[j] <= from_next;
          end
        end
        otq_pkg::ST_INSERT: begin
          if (IW'(j) == pos) begin
            slot_r[j] <= req.entry;
          end else if (IW'(j) > pos) begin
            slot_r[j] <= from_prev;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* src/otq_ctrl.sv */
// Command sequencer: scans the store one entry per cycle through the
// shared compare unit and keeps the current time and the fill count.
module otq_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_cmd,
  input  logic [3:0]                  in_timer_id,
  input  logic [31:0]                 in_deadline_coarse,
  input  logic [19:0]                 in_deadline_fine,
  output otq_pkg::otq_store_req_t     st_req,
  output logic [$clog2(DEPTH)-1:0]    st_pos,
  output logic [$clog2(DEPTH)-1:0]    st_rd_idx,
  input  otq_pkg::otq_entry_t         st_rd_entry,
  input  logic                        out_free,
  output logic                        res_load,
  output otq_pkg::otq_result_t        res
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  otq_pkg::otq_state_t state_r, state_nxt;
  otq_pkg::otq_cmd_t   cmd_r, cmd_nxt;
  otq_pkg::otq_kind_t  kind_r, kind_nxt;
  logic [3:0]          id_r, id_nxt;
  logic [31:0]         dc_r, dc_nxt;
  logic [19:0]         df_r, df_nxt;
  logic [31:0]         now_c_r, now_c_nxt;
  logic [19:0]         now_f_r, now_f_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic                found_r, found_nxt;
  logic                dup_r, dup_nxt;
  logic                was_r, was_nxt;

  logic                use_now;
  logic [31:0]         b_coarse;
  logic [19:0]         b_fine;
  logic                lt;
  logic                id_eq;

  // Operand B of the compare unit is either the current time or the entry
  // under the scan; operand A is always the command's deadline or target.
  assign b_coarse = use_now ? now_c_r : st_rd_entry.coarse;
  assign b_fine   = use_now ? now_f_r : st_rd_entry.fine;

  otq_cmp u_cmp (
    .a_id     (id_r),
    .a_coarse (dc_r),
    .a_fine   (df_r),
    .b_id     (st_rd_entry.id),
    .b_coarse (b_coarse),
    .b_fine   (b_fine),
    .a_lt_b   (lt),
    .id_eq    (id_eq)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= otq_pkg::S_IDLE;
      now_c_r <= '0;
      now_f_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      now_c_r <= now_c_nxt;
      now_f_r <= now_f_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers of the command in progress.
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    kind_r  <= kind_nxt;
    id_r    <= id_nxt;
    dc_r    <= dc_nxt;
    df_r    <= df_nxt;
    idx_r   <= idx_nxt;
    pos_r   <= pos_nxt;
    found_r <= found_nxt;
    dup_r   <= dup_nxt;
    was_r   <= was_nxt;
  end

  // Next state and outputs.
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    kind_nxt  = kind_r;
    id_nxt    = id_r;
    dc_nxt    = dc_r;
    df_nxt    = df_r;
    now_c_nxt = now_c_r;
    now_f_nxt = now_f_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    found_nxt = found_r;
    dup_nxt   = dup_r;
    was_nxt   = was_r;

    in_ready        = 1'b0;
    use_now         = 1'b0;
    st_req.op       = otq_pkg::ST_NOP;
    st_req.entry.id     = id_r;
    st_req.entry.coarse = dc_r;
    st_req.entry.fine   = df_r;
    st_pos          = idx_r[IW-1:0];
    st_rd_idx       = idx_r[IW-1:0];
    res_load        = 1'b0;
    res.kind        = kind_r;
    res.fired_id    = '0;
    res.time_coarse = now_c_r;
    res.time_fine   = now_f_r;
    res.was_present = was_r;
    res.last        = 1'b1;

    unique case (state_r)
      otq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt = otq_pkg::otq_cmd_t'(in_cmd);
          id_nxt  = in_timer_id;
          dc_nxt  = in_deadline_coarse;
          // Modify re-adds the timer with a zero sub-tick.
          df_nxt  = (otq_pkg::otq_cmd_t'(in_cmd) == otq_pkg::CMD_MODIFY) ?
                    '0 : in_deadline_fine;
          was_nxt = 1'b0;
          idx_nxt = '0;
          unique case (otq_pkg::otq_cmd_t'(in_cmd))
            otq_pkg::CMD_ADD:    state_nxt = otq_pkg::S_ADD_CHK;
            otq_pkg::CMD_DELETE,
            otq_pkg::CMD_MODIFY: state_nxt = otq_pkg::S_DEL_SCAN;
            default:             state_nxt = otq_pkg::S_ADV_CHK;
          endcase
        end
      end

      // Look for the id; remove it where it is found.
      otq_pkg::S_DEL_SCAN: begin
        if ((idx_r == count_r) || id_eq) begin
          if (idx_r != count_r) begin
            st_req.op = otq_pkg::ST_REMOVE;
            count_nxt = count_r - CW'(1);
            was_nxt   = 1'b1;
          end
          if (cmd_r == otq_pkg::CMD_MODIFY) begin
            state_nxt = otq_pkg::S_ADD_CHK;
          end else begin
            kind_nxt  = otq_pkg::KIND_DONE;
            state_nxt = otq_pkg::S_RESULT;
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end

      // Reject a deadline in the past or a full queue.
      otq_pkg::S_ADD_CHK: begin
        use_now = 1'b1;
        if (lt || (count_r == CW'(DEPTH))) begin
          kind_nxt  = otq_pkg::KIND_ERROR;
          state_nxt = otq_pkg::S_RESULT;
        end else begin
          idx_nxt   = '0;
          pos_nxt   = count_r;
          found_nxt = 1'b0;
          dup_nxt   = 1'b0;
          state_nxt = otq_pkg::S_ADD_SCAN;
        end
      end

      // Full scan: find the first later deadline and any duplicate id.
      otq_pkg::S_ADD_SCAN: begin
        st_pos = pos_r[IW-1:0];
        if (idx_r == count_r) begin
          if (dup_r) begin
            kind_nxt = otq_pkg::KIND_ERROR;
          end else begin
            st_req.op = otq_pkg::ST_INSERT;
            count_nxt = count_r + CW'(1);
            kind_nxt  = otq_pkg::KIND_DONE;
          end
          state_nxt = otq_pkg::S_RESULT;
        end else begin
          if (id_eq) begin
            dup_nxt = 1'b1;
          end
          if (lt && !found_r) begin
            pos_nxt   = idx_r;
            found_nxt = 1'b1;
          end
          idx_nxt = idx_r + CW'(1);
        end
      end

      // Reject a target in the past.
      otq_pkg::S_ADV_CHK: begin
        use_now = 1'b1;
        if (lt) begin
          kind_nxt = otq_pkg::KIND_ERROR;
        end
        state_nxt = lt ? otq_pkg::S_RESULT : otq_pkg::S_ADV_FIRE;
      end

      // Fire the head timer while it is due, one per output transaction.
      otq_pkg::S_ADV_FIRE: begin
        st_rd_idx = '0;
        st_pos    = '0;
        if ((count_r == '0) || lt) begin
          now_c_nxt = dc_r;
          now_f_nxt = df_r;
          kind_nxt  = otq_pkg::KIND_DONE;
          state_nxt = otq_pkg::S_RESULT;
        end else if (out_free) begin
          res_load        = 1'b1;
          res.kind        = otq_pkg::KIND_FIRED;
          res.fired_id    = st_rd_entry.id;
          res.time_coarse = st_rd_entry.coarse;
          res.time_fine   = st_rd_entry.fine;
          res.was_present = 1'b0;
          res.last        = 1'b0;
          now_c_nxt       = st_rd_entry.coarse;
          now_f_nxt       = st_rd_entry.fine;
          st_req.op       = otq_pkg::ST_REMOVE;
          count_nxt       = count_r - CW'(1);
        end
      end

      // Final result of the command.
      otq_pkg::S_RESULT: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = otq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = otq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* src/ordered_timer_queue_top.sv */
// Channel   Direction  Handshake      Payload
// in_chan   input      valid / ready  cmd, timer_id, deadline_coarse, deadline_fine
// out_chan  output     valid / ready  kind, fired_id, time_coarse, time_fine,
//                                     was_present, last
//
// One command is taken at a time; in_chan.ready is high only while idle.
// Add, delete and modify scan the queued timers one entry per cycle
// through the single compare unit; advance removes the due timers from
// the head, one per output transaction.
// A full output register stalls the sequencer until out_chan.ready.
// Reset is synchronous and empties the queue with time set to zero.
module ordered_timer_queue_top #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  otq_in_if.sink       in_chan,
  otq_out_if.source    out_chan
);

  localparam int unsigned DEPTH =
    (NUM_TIMERS < otq_pkg::MAX_IDS) ? NUM_TIMERS : otq_pkg::MAX_IDS;
  localparam int unsigned IW = $clog2(DEPTH);

  otq_pkg::otq_store_req_t st_req;
  logic [IW-1:0]           st_pos;
  logic [IW-1:0]           st_rd_idx;
  otq_pkg::otq_entry_t     st_rd_entry;
  logic                    out_free;
  logic                    res_load;
  otq_pkg::otq_result_t    res;
  logic                    out_valid_r;
  otq_pkg::otq_result_t    out_data_r;

  otq_store #(.DEPTH(DEPTH)) u_store (
    .clk      (clk),
    .req      (st_req),
    .pos      (st_pos),
    .rd_idx   (st_rd_idx),
    .rd_entry (st_rd_entry)
  );

  otq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_chan.valid),
    .in_ready           (in_chan.ready),
    .in_cmd             (in_chan.cmd),
    .in_timer_id        (in_chan.timer_id),
    .in_deadline_coarse (in_chan.deadline_coarse),
    .in_deadline_fine   (in_chan.deadline_fine),
    .st_req             (st_req),
    .st_pos             (st_pos),
    .st_rd_idx          (st_rd_idx),
    .st_rd_entry        (st_rd_entry),
    .out_free           (out_free),
    .res_load           (res_load),
    .res                (res)
  );

  // Output register: free when empty or taken in this cycle.
  assign out_free = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.kind        = out_data_r.kind;
  assign out_chan.fired_id    = out_data_r.fired_id;
  assign out_chan.time_coarse = out_data_r.time_coarse;
  assign out_chan.time_fine   = out_data_r.time_fine;
  assign out_chan.was_present = out_data_r.was_present;
  assign out_chan.last        = out_data_r.last;

endmodule

/* src/otq_checker.sv */
// Port-level checks on the timer queue.
module otq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [3:0]  out_fired_id,
  input logic        out_last
);

  // A held result transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
    $stable(out_fired_id) && $stable(out_last))
    else $error("result changed while stalled");

  // The block works on one command at a time.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a command is in progress");

  // A fired timer is never the closing result; errors always close.
  a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == otq_pkg::KIND_FIRED) |-> !out_last)
    else $error("fired result marked last");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == otq_pkg::KIND_ERROR) |-> out_last)
    else $error("error result not marked last");

  // Only fired results carry an id.
  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != otq_pkg::KIND_FIRED) |-> (out_fired_id == 4'd0))
    else $error("id set on a result that is not a firing");

endmodule

bind ordered_timer_queue_top otq_checker u_otq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_kind     (out_chan.kind),
  .out_fired_id (out_chan.fired_id),
  .out_last     (out_chan.last)
);

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NUM_TIMERS    = 16;
  localparam int unsigned CAPACITY      =
    (NUM_TIMERS < otq_pkg::MAX_IDS) ? NUM_TIMERS : otq_pkg::MAX_IDS;
  localparam int unsigned PHASE_ITEMS   = 115;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    otq_pkg::otq_cmd_t cmd;
    logic [3:0]        id;
    logic [31:0]       coarse;
    logic [19:0]       fine;
  } timer_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  otq_in_if  in_if ();
  otq_out_if out_if ();

  ordered_timer_queue_top #(.NUM_TIMERS(NUM_TIMERS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Free-running clock, 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Commands waiting to be offered, and the results the queue must produce.
  timer_cmd_t           cmd_backlog[$];
  otq_pkg::otq_result_t timer_events[$];

  int unsigned cmds_queued    = 0;
  int unsigned cmds_taken     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;

  // Long receiver hold-off, requested by the stimulus and counted here.
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;

  // Shadow of the timer queue, used to work out the expected results.
  logic [31:0] clock_coarse = '0;
  logic [19:0] clock_fine   = '0;
  logic [3:0]  sched_id     [otq_pkg::MAX_IDS];
  logic [31:0] sched_coarse [otq_pkg::MAX_IDS];
  logic [19:0] sched_fine   [otq_pkg::MAX_IDS];
  int unsigned sched_count  = 0;

  // Current time as the stimulus sees it, once every queued command has run.
  logic [31:0] gen_coarse = '0;
  logic [19:0] gen_fine   = '0;

  // True when deadline a lies strictly before deadline b.
  function automatic bit earlier(logic [31:0] ac, logic [19:0] af,
                                 logic [31:0] bc, logic [19:0] bf);
    return (ac < bc) || ((ac == bc) && (af < bf));
  endfunction

  function automatic void emit(otq_pkg::otq_kind_t kind, logic [3:0] id, logic was,
                               logic last);
    otq_pkg::otq_result_t r;
    r.kind        = kind;
    r.fired_id    = id;
    r.time_coarse = clock_coarse;
    r.time_fine   = clock_fine;
    r.was_present = was;
    r.last        = last;
    timer_events.push_back(r);
  endfunction

  function automatic void drop_at(int unsigned pos);
    for (int unsigned i = pos; i + 1 < sched_count; i++) begin
      sched_id[i]     = sched_id[i + 1];
      sched_coarse[i] = sched_coarse[i + 1];
      sched_fine[i]   = sched_fine[i + 1];
    end
    sched_count--;
  endfunction

  function automatic bit drop_id(logic [3:0] id);
    for (int unsigned i = 0; i < sched_count; i++) begin
      if (sched_id[i] == id) begin
        drop_at(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Inserts behind every timer that is due no later, so ties keep their order.
  function automatic bit place(logic [3:0] id, logic [31:0] c, logic [19:0] f);
    int unsigned pos;
    if (earlier(c, f, clock_coarse, clock_fine)) return 1'b0;
    if (sched_count >= CAPACITY) return 1'b0;
    for (int unsigned i = 0; i < sched_count; i++)
      if (sched_id[i] == id) return 1'b0;
    pos = sched_count;
    for (int unsigned i = 0; i < sched_count; i++) begin
      if (earlier(c, f, sched_coarse[i], sched_fine[i])) begin
        pos = i;
        break;
      end
    end
    for (int unsigned i = sched_count; i > pos; i--) begin
      sched_id[i]     = sched_id[i - 1];
      sched_coarse[i] = sched_coarse[i - 1];
      sched_fine[i]   = sched_fine[i - 1];
    end
    sched_id[pos]     = id;
    sched_coarse[pos] = c;
    sched_fine[pos]   = f;
    sched_count++;
    return 1'b1;
  endfunction

  // Applies one accepted command to the shadow queue and records its results.
  function automatic void run_timer_cmd(timer_cmd_t c);
    bit         was;
    bit         ok;
    logic [3:0] fid;
    case (c.cmd)
      otq_pkg::CMD_ADD: begin
        ok = place(c.id, c.coarse, c.fine);
        emit(ok ? otq_pkg::KIND_DONE : otq_pkg::KIND_ERROR, 4'd0, 1'b0, 1'b1);
      end
      otq_pkg::CMD_DELETE: begin
        was = drop_id(c.id);
        emit(otq_pkg::KIND_DONE, 4'd0, was, 1'b1);
      end
      otq_pkg::CMD_MODIFY: begin
        was = drop_id(c.id);
        ok  = place(c.id, c.coarse, 20'd0);
        emit(ok ? otq_pkg::KIND_DONE : otq_pkg::KIND_ERROR, 4'd0, was, 1'b1);
      end
      default: begin
        if (earlier(c.coarse, c.fine, clock_coarse, clock_fine)) begin
          emit(otq_pkg::KIND_ERROR, 4'd0, 1'b0, 1'b1);
        end else begin
          // Fire every timer that is due by the target, in queue order.
          while (sched_count > 0 &&
                 !earlier(c.coarse, c.fine, sched_coarse[0], sched_fine[0])) begin
            fid          = sched_id[0];
            clock_coarse = sched_coarse[0];
            clock_fine   = sched_fine[0];
            drop_at(0);
            emit(otq_pkg::KIND_FIRED, fid, 1'b0, 1'b0);
          end
          clock_coarse = c.coarse;
          clock_fine   = c.fine;
          emit(otq_pkg::KIND_DONE, 4'd0, 1'b0, 1'b1);
        end
      end
    endcase
  endfunction

  function automatic void queue_cmd(otq_pkg::otq_cmd_t cmd, logic [3:0] id,
                                    logic [31:0] c, logic [19:0] f);
    timer_cmd_t t;
    t.cmd    = cmd;
    t.id     = id;
    t.coarse = c;
    t.fine   = f;
    cmd_backlog.push_back(t);
    cmds_queued++;
    // Only an advance that is not rejected moves the time.
    if (cmd == otq_pkg::CMD_ADVANCE && !earlier(c, f, gen_coarse, gen_fine)) begin
      gen_coarse = c;
      gen_fine   = f;
    end
  endfunction

  function automatic logic [19:0] pick_fine();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 20'($urandom_range(0, 20'hFFFFF));
    if (roll < 10) return 20'd0;
    if (roll < 18) return gen_fine;
    return 20'($urandom_range(0, 999999));
  endfunction

  // Mostly adds near the current time and advances that fire a few timers.
  function automatic void queue_random_cmd();
    int unsigned roll;
    int unsigned sub;
    logic [3:0]  id;
    logic [31:0] c;
    logic [19:0] f;
    logic [31:0] behind;
    roll   = $urandom_range(0, 99);
    sub    = $urandom_range(0, 99);
    id     = 4'($urandom_range(0, 15));
    f      = pick_fine();
    behind = (gen_coarse > 3) ? gen_coarse - $urandom_range(0, 3) : gen_coarse;
    if (sub < 85)      c = gen_coarse + $urandom_range(0, 30);
    else if (sub < 97) c = behind;
    else               c = $urandom;
    if (roll < 40) begin
      queue_cmd(otq_pkg::CMD_ADD, id, c, f);
    end else if (roll < 55) begin
      queue_cmd(otq_pkg::CMD_DELETE, id, $urandom, 20'($urandom_range(0, 20'hFFFFF)));
    end else if (roll < 70) begin
      queue_cmd(otq_pkg::CMD_MODIFY, id, c, 20'($urandom_range(0, 20'hFFFFF)));
    end else begin
      if (sub < 75)
        queue_cmd(otq_pkg::CMD_ADVANCE, 4'd0, gen_coarse + $urandom_range(0, 20), f);
      else if (sub < 80)
        queue_cmd(otq_pkg::CMD_ADVANCE, 4'd0, gen_coarse + $urandom_range(0, 200), f);
      else if (sub < 95)
        queue_cmd(otq_pkg::CMD_ADVANCE, 4'd0, behind, f);
      else
        queue_cmd(otq_pkg::CMD_ADVANCE, id, gen_coarse, gen_fine);
    end
  endfunction

  task automatic drain_backlog();
    while (cmds_taken != cmds_queued) @(negedge clk);
  endtask

  // Driver: offers pending commands and predicts each accepted transaction.
  always @(posedge clk) begin
    timer_cmd_t nxt;
    timer_cmd_t seen;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        seen.cmd    = otq_pkg::otq_cmd_t'(in_if.cmd);
        seen.id     = in_if.timer_id;
        seen.coarse = in_if.deadline_coarse;
        seen.fine   = in_if.deadline_fine;
        run_timer_cmd(seen);
        cmds_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = cmd_backlog.pop_front();
          in_if.valid           <= 1'b1;
          in_if.cmd             <= nxt.cmd;
          in_if.timer_id        <= nxt.id;
          in_if.deadline_coarse <= nxt.coarse;
          in_if.deadline_fine   <= nxt.fine;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest expectation.
  always @(posedge clk) begin
    otq_pkg::otq_result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (timer_events.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result kind=%0d id=%0d time=%0d.%0d was=%0b last=%0b",
                   $time, out_if.kind, out_if.fired_id, out_if.time_coarse,
                   out_if.time_fine, out_if.was_present, out_if.last);
        end else begin
          want = timer_events.pop_front();
          if (want.kind !== out_if.kind || want.fired_id !== out_if.fired_id ||
              want.time_coarse !== out_if.time_coarse ||
              want.time_fine !== out_if.time_fine ||
              want.was_present !== out_if.was_present || want.last !== out_if.last) begin
            error_count++;
            $display("%0t: mismatch expected kind=%0d id=%0d time=%0d.%0d was=%0b last=%0b",
                     $time, want.kind, want.fired_id, want.time_coarse,
                     want.time_fine, want.was_present, want.last);
            $display("%0t:          actual   kind=%0d id=%0d time=%0d.%0d was=%0b last=%0b",
                     $time, out_if.kind, out_if.fired_id, out_if.time_coarse,
                     out_if.time_fine, out_if.was_present, out_if.last);
          end
        end
      end
      out_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Hold-off counter: keeps the receiver stalled for a long stretch on request.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stimulus: directed commands, then random phases with different idling.
  initial begin
    int unsigned i;
    int unsigned p;
    logic [31:0] c;
    logic [19:0] f;
    in_if.valid           = 1'b0;
    in_if.cmd             = otq_pkg::CMD_ADD;
    in_if.timer_id        = 4'd0;
    in_if.deadline_coarse = '0;
    in_if.deadline_fine   = '0;
    out_if.ready          = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty queue: advance to the current time, delete and modify of absent ids.
    queue_cmd(otq_pkg::CMD_ADVANCE, 4'd0, 32'd0, 20'd0);
    queue_cmd(otq_pkg::CMD_DELETE, 4'd3, 32'd0, 20'd0);
    queue_cmd(otq_pkg::CMD_MODIFY, 4'd5, 32'd10, 20'h12345);
    queue_cmd(otq_pkg::CMD_ADD, 4'd5, 32'd20, 20'd0);
    // Equal deadlines keep insertion order; an earlier one goes in front.
    queue_cmd(otq_pkg::CMD_ADD, 4'd0, 32'd10, 20'd0);
    queue_cmd(otq_pkg::CMD_ADD, 4'd15, 32'd4, 20'd999999);
    queue_cmd(otq_pkg::CMD_ADVANCE, 4'd0, 32'd10, 20'd0);
    // Deadlines and targets in the past are rejected.
    queue_cmd(otq_pkg::CMD_ADD, 4'd2, 32'd9, 20'hFFFFF);
    queue_cmd(otq_pkg::CMD_MODIFY, 4'd2, 32'd3, 20'd0);
    queue_cmd(otq_pkg::CMD_ADVANCE, 4'd0, 32'd9, 20'd7);
    // Fill the queue, then try one more.
    for (i = 0; i < otq_pkg::MAX_IDS; i++) begin
      if (i == 15) begin
        c = 32'hFFFF_FFFF;
        f = 20'hFFFFF;
      end else if (i == 14) begin
        c = 32'h8000_0000;
        f = 20'h55555;
      end else begin
        c = 32'd10 + (i % 4);
        f = (i % 3 == 0) ? 20'hFFFFF : ((i % 3 == 1) ? 20'd0 : 20'd999999);
      end
      queue_cmd(otq_pkg::CMD_ADD, 4'(i), c, f);
    end
    queue_cmd(otq_pkg::CMD_ADD, 4'd7, 32'd50, 20'd0);
    queue_cmd(otq_pkg::CMD_ADVANCE, 4'd0, 32'd100, 20'd999999);
    drain_backlog();

    // Random phases; the first one also stalls the receiver for a long stretch.
    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_requests++; end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) queue_random_cmd();
      drain_backlog();
    end

    // The end of time: fire everything left, then work at the latest deadline.
    queue_cmd(otq_pkg::CMD_ADVANCE, 4'd0, 32'hFFFF_FFFF, 20'hFFFFF);
    queue_cmd(otq_pkg::CMD_ADD, 4'd9, 32'hFFFF_FFFF, 20'hFFFFF);
    queue_cmd(otq_pkg::CMD_ADD, 4'd9, 32'hFFFF_FFFF, 20'hFFFFF);
    queue_cmd(otq_pkg::CMD_MODIFY, 4'd9, 32'hFFFF_FFFF, 20'hFFFFF);
    queue_cmd(otq_pkg::CMD_DELETE, 4'd9, 32'hFFFF_FFFF, 20'hFFFFF);
    queue_cmd(otq_pkg::CMD_ADD, 4'd12, 32'hFFFF_FFFF, 20'hFFFFF);
    queue_cmd(otq_pkg::CMD_ADVANCE, 4'd0, 32'hFFFF_FFFF, 20'hFFFFF);
    drain_backlog();

    while (timer_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && timer_events.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
